// File: hdl/http_chunked_body_decoder_top_macros.svh
// Assertion macros used by the chunked body decoder checker.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define HCBD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcbd check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define HCBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcbd check failed");

`endif

// File: hdl/hcbd_pkg.sv
// Types, codes and helpers for the chunked body decoder.
package hcbd_pkg;

  typedef enum logic [11:0] {
    PH_SKIP     = 12'b0000_0000_0001,
    PH_SIZE     = 12'b0000_0000_0010,
    PH_EXT      = 12'b0000_0000_0100,
    PH_SIZE_LF  = 12'b0000_0000_1000,
    PH_PAYLOAD  = 12'b0000_0001_0000,
    PH_DATA_CR  = 12'b0000_0010_0000,
    PH_DATA_LF  = 12'b0000_0100_0000,
    PH_TR_START = 12'b0000_1000_0000,
    PH_TR_LINE  = 12'b0001_0000_0000,
    PH_TR_LF    = 12'b0010_0000_0000,
    PH_DONE     = 12'b0100_0000_0000,
    PH_ERROR    = 12'b1000_0000_0000
  } phase_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_RUNNING    = 2'd0;
  localparam status_t ST_DONE       = 2'd1;
  localparam status_t ST_ERROR      = 2'd2;
  localparam status_t ST_INCOMPLETE = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_body;
    logic        last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    status_t     status;
    logic [31:0] decoded_count;
    logic [31:0] consumed_count;
  } result_t;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  // Phases in which bytes are still parsed.
  function automatic logic phase_active(input phase_t p);
    logic a;
    a = 1'b0;
    case (p) inside
      PH_SKIP, PH_SIZE, PH_EXT, PH_SIZE_LF, PH_PAYLOAD, PH_DATA_CR, PH_DATA_LF,
      PH_TR_START, PH_TR_LINE, PH_TR_LF: a = 1'b1;
      default: a = 1'b0;
    endcase
    return a;
  endfunction

endpackage

// File: hdl/hcbd_ifs.sv
// Channel interfaces of the chunked body decoder.
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_body;
  logic       last_byte;
  modport source (output valid, data_byte, start_of_body, last_byte, input ready);
  modport sink   (input valid, data_byte, start_of_body, last_byte, output ready);
endinterface

interface hcbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic [1:0]  status;
  logic [31:0] decoded_count;
  logic [31:0] consumed_count;
  modport source (output valid, payload_byte, payload_valid, status, decoded_count,
                  consumed_count, input ready);
  modport sink   (input valid, payload_byte, payload_valid, status, decoded_count,
                  consumed_count, output ready);
endinterface

interface hcbd_cfg_if;
  logic valid;
  logic ready;
  logic content_length_present;
  modport source (output valid, content_length_present, input ready);
  modport sink   (input valid, content_length_present, output ready);
endinterface

// File: hdl/http_chunked_body_decoder_top.sv
// A beat is held in the input register, its result (if any) in the result register.
// Throughput: one body beat per cycle unless a full result register is stalled.
// Beats that cause no result still take one slot in the input register.
// Reset (rst, synchronous): clears parse state, config bit and both valid flags.
// Top level of the HTTP/1.1 chunked transfer decoder.
module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS  = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  hcbd_in_if.sink      body_in,
  hcbd_out_if.source   result_out,
  hcbd_cfg_if.sink     cfg
);

  hcbd_pkg::item_t    in_item, held_item;
  hcbd_pkg::result_t  step_result, out_data;
  logic               held_valid, advance, can_take, has_result;
  logic               cl_present;

  // Config reg always ready; user must write it only while decoder idle, unchecked.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cl_present <= 1'b0;
    end else if (cfg.valid) begin
      cl_present <= cfg.content_length_present;
    end
  end

  assign in_item.data_byte     = body_in.data_byte;
  assign in_item.start_of_body = body_in.start_of_body;
  assign in_item.last_byte     = body_in.last_byte;

  // The held beat is parsed whenever the result register has room for it,
  // whether or not it produces a result.
  assign advance = held_valid && can_take;

  hcbd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (body_in.valid),
    .in_ready   (body_in.ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  hcbd_parser #(
    .SIZE_BITS  (SIZE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (held_item),
    .cl_present (cl_present),
    .has_result (has_result),
    .result     (step_result)
  );

  hcbd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_result),
    .load_data (step_result),
    .can_take  (can_take),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (out_data)
  );

  assign result_out.payload_byte   = out_data.payload_byte;
  assign result_out.payload_valid  = out_data.payload_valid;
  assign result_out.status         = out_data.status;
  assign result_out.decoded_count  = out_data.decoded_count;
  assign result_out.consumed_count = out_data.consumed_count;

endmodule

// File: hdl/hcbd_in_reg.sv
// Input register stage: holds one body beat until the parser takes it.
module hcbd_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hcbd_pkg::item_t    in_item,
  input  logic               advance,
  output logic               held_valid,
  output hcbd_pkg::item_t    held_item
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// File: hdl/hcbd_parser.sv
// Chunked framing parser: parse state and the one-byte step logic.
module hcbd_parser #(
  parameter int SIZE_BITS  = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  hcbd_pkg::item_t     item,
  input  logic                cl_present,
  output logic                has_result,
  output hcbd_pkg::result_t   result
);

  hcbd_pkg::phase_t        phase, phase_next, cur_phase;
  logic [SIZE_BITS-1:0]    remaining, remaining_next, cur_rem, rem_dec;
  logic                    seen, seen_next, cur_seen;
  logic [COUNT_BITS-1:0]   total, total_next, cur_total;
  logic [COUNT_BITS-1:0]   consumed, consumed_next, cur_cons;
  logic [4:0]              hv;
  logic                    emit, ended;
  logic [7:0]              b;
  logic [31:0]             dec32, cons32;

  assign b  = item.data_byte;
  assign hv = hcbd_pkg::hex_nibble(b);

  always_comb begin
    cur_phase = item.start_of_body ? hcbd_pkg::PH_SKIP : phase;
    cur_rem   = item.start_of_body ? '0 : remaining;
    cur_seen  = item.start_of_body ? 1'b0 : seen;
    cur_total = item.start_of_body ? '0 : total;
    cur_cons  = item.start_of_body ? '0 : consumed;

    phase_next     = cur_phase;
    remaining_next = cur_rem;
    seen_next      = cur_seen;
    total_next     = cur_total;
    consumed_next  = cur_cons;
    rem_dec        = cur_rem - SIZE_BITS'(1);
    emit           = 1'b0;
    ended          = 1'b0;

    if (hcbd_pkg::phase_active(cur_phase)) begin
      consumed_next = cur_cons + COUNT_BITS'(1);
      if (cl_present) begin
        phase_next = hcbd_pkg::PH_ERROR;
      end else begin
        unique case (cur_phase) inside
          hcbd_pkg::PH_SKIP, hcbd_pkg::PH_SIZE: begin
            if (cur_phase == hcbd_pkg::PH_SKIP && (b == hcbd_pkg::CH_CR ||
                b == hcbd_pkg::CH_LF)) begin
              phase_next = cur_phase;
            end else if (hv[4]) begin
              if (cur_rem[SIZE_BITS-1 -: 4] != 4'd0) begin
                phase_next = hcbd_pkg::PH_ERROR;
              end else begin
                remaining_next = {cur_rem[SIZE_BITS-5:0], hv[3:0]};
                seen_next      = 1'b1;
                phase_next     = hcbd_pkg::PH_SIZE;
              end
            end else if ((b == hcbd_pkg::CH_SEMI || b == hcbd_pkg::CH_SPACE) &&
                         cur_seen) begin
              phase_next = hcbd_pkg::PH_EXT;
            end else if (b == hcbd_pkg::CH_CR && cur_seen) begin
              phase_next = hcbd_pkg::PH_SIZE_LF;
            end else begin
              phase_next = hcbd_pkg::PH_ERROR;
            end
          end
          hcbd_pkg::PH_EXT: begin
            if (b == hcbd_pkg::CH_CR) phase_next = hcbd_pkg::PH_SIZE_LF;
            else if (b == hcbd_pkg::CH_LF) phase_next = hcbd_pkg::PH_ERROR;
          end
          hcbd_pkg::PH_SIZE_LF: begin
            if (b != hcbd_pkg::CH_LF) phase_next = hcbd_pkg::PH_ERROR;
            else if (cur_rem == '0) phase_next = hcbd_pkg::PH_TR_START;
            else phase_next = hcbd_pkg::PH_PAYLOAD;
          end
          hcbd_pkg::PH_PAYLOAD: begin
            emit           = 1'b1;
            total_next     = cur_total + COUNT_BITS'(1);
            remaining_next = rem_dec;
            if (rem_dec == '0) phase_next = hcbd_pkg::PH_DATA_CR;
          end
          hcbd_pkg::PH_DATA_CR: begin
            phase_next = (b == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_DATA_LF
                                                : hcbd_pkg::PH_ERROR;
          end
          hcbd_pkg::PH_DATA_LF: begin
            if (b == hcbd_pkg::CH_LF) begin
              phase_next = hcbd_pkg::PH_SKIP;
              seen_next  = 1'b0;
            end else begin
              phase_next = hcbd_pkg::PH_ERROR;
            end
          end
          hcbd_pkg::PH_TR_START, hcbd_pkg::PH_TR_LINE: begin
            if (b == hcbd_pkg::CH_CR) phase_next = hcbd_pkg::PH_TR_LF;
            else if (b == hcbd_pkg::CH_LF) phase_next = hcbd_pkg::PH_DONE;
            else phase_next = hcbd_pkg::PH_TR_LINE;
          end
          hcbd_pkg::PH_TR_LF: begin
            phase_next = (b == hcbd_pkg::CH_LF) ? hcbd_pkg::PH_DONE
                                                : hcbd_pkg::PH_ERROR;
          end
          default: phase_next = hcbd_pkg::PH_ERROR;
        endcase
      end
      ended = !hcbd_pkg::phase_active(phase_next);
    end
  end

  // Expose the low 32 bits of the counters.
  generate
    if (COUNT_BITS >= 32) begin : g_wide
      assign dec32  = total_next[31:0];
      assign cons32 = consumed_next[31:0];
    end else begin : g_narrow
      assign dec32  = {{(32-COUNT_BITS){1'b0}}, total_next};
      assign cons32 = {{(32-COUNT_BITS){1'b0}}, consumed_next};
    end
  endgenerate

  always_comb begin
    result.payload_byte   = emit ? b : 8'd0;
    result.payload_valid  = emit;
    result.decoded_count  = dec32;
    result.consumed_count = cons32;
    if (phase_next == hcbd_pkg::PH_DONE) result.status = hcbd_pkg::ST_DONE;
    else if (!hcbd_pkg::phase_active(phase_next)) result.status = hcbd_pkg::ST_ERROR;
    else if (item.last_byte) result.status = hcbd_pkg::ST_INCOMPLETE;
    else result.status = hcbd_pkg::ST_RUNNING;
  end

  assign has_result = emit || ended || item.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= hcbd_pkg::PH_SKIP;
      remaining <= '0;
      seen      <= 1'b0;
      total     <= '0;
      consumed  <= '0;
    end else if (step) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      seen      <= seen_next;
      total     <= total_next;
      consumed  <= consumed_next;
    end
  end

endmodule

// File: hdl/hcbd_out_reg.sv
// Result register: one result beat toward the sink.
module hcbd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  hcbd_pkg::result_t   load_data,
  output logic                can_take,
  output logic                out_valid,
  input  logic                out_ready,
  output hcbd_pkg::result_t   out_data
);

  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_take) begin
      out_data <= load_data;
    end
  end

endmodule

// File: hdl/hcbd_checker.sv
// Port-level checks for the chunked body decoder, bound to the top level.
`include "http_chunked_body_decoder_top_macros.svh"

module hcbd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  payload_byte,
  input logic        payload_valid,
  input logic [1:0]  status,
  input logic [31:0] decoded_count
);

  `HCBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(decoded_count))
  `HCBD_ASSERT_NOW(a_payload_running, out_valid && payload_valid, status == hcbd_pkg::ST_RUNNING || status == hcbd_pkg::ST_INCOMPLETE)
  `HCBD_ASSERT_NOW(a_no_payload_zero, out_valid && !payload_valid, payload_byte == 8'd0)

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result_out.valid),
  .out_ready     (result_out.ready),
  .payload_byte  (result_out.payload_byte),
  .payload_valid (result_out.payload_valid),
  .status        (result_out.status),
  .decoded_count (result_out.decoded_count)
);

// File: test/http_chunked_body_decoder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the HTTP/1.1 chunked body decoder top level.
module http_chunked_body_decoder_top_tb;

  localparam int SIZE_BITS   = 32;
  localparam int COUNT_BITS  = 32;
  // Largest size that still takes one more hex digit without overflow.
  localparam logic [SIZE_BITS-1:0] SIZE_SHIFT_MAX = {4'h0, {(SIZE_BITS - 4){1'b1}}};
  // Cycles with no beat on any channel before the run is declared hung.
  // Worst honest case is a sender gap plus a receiver stall plus settling.
  localparam int STALL_LIMIT = 200;
  // Cycles to let a beat that causes no result clear the input register.
  localparam int SETTLE_CYCLES = 4;

  // Directed plan: body beats and register writes, walked in order.
  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic      cfg_value;
    logic [7:0] data;
    logic      sob;
    logic      last;
    logic      pinned;   // want is typed in and used instead of the predictor
    hcbd_pkg::result_t want;
  } row_t;

  localparam hcbd_pkg::result_t NONE = '0;

  localparam row_t PLAN [29] = '{
    // Right after reset, refuse bit at its reset value 0.
    // "2" with last_byte: truncated while parsing the size line.
    '{ROW_BEAT, 1'b0, 8'h32, 1'b1, 1'b1, 1'b1,
      '{8'h00, 1'b0, hcbd_pkg::ST_INCOMPLETE, 32'd0, 32'd1}},
    '{ROW_BEAT, 1'b0, hcbd_pkg::CH_SPACE, 1'b0, 1'b0, 1'b0, NONE},   // padding-style extension
    '{ROW_BEAT, 1'b0, hcbd_pkg::CH_CR, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, hcbd_pkg::CH_LF, 1'b0, 1'b0, 1'b0, NONE},
    // Payload byte extremes; the second one also flags truncation.
    '{ROW_BEAT, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
      '{8'h00, 1'b1, hcbd_pkg::ST_RUNNING, 32'd1, 32'd5}},
    '{ROW_BEAT, 1'b0, 8'hFF, 1'b0, 1'b1, 1'b1,
      '{8'hFF, 1'b1, hcbd_pkg::ST_INCOMPLETE, 32'd2, 32'd6}},
    '{ROW_BEAT, 1'b0, hcbd_pkg::CH_CR, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, hcbd_pkg::CH_LF, 1'b0, 1'b0, 1'b0, NONE},
    // Last chunk, then a trailer line closed by a bare LF.
    '{ROW_BEAT, 1'b0, 8'h30, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, hcbd_pkg::CH_CR, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, hcbd_pkg::CH_LF, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 8'h54, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, hcbd_pkg::CH_LF, 1'b0, 1'b0, 1'b1,
      '{8'h00, 1'b0, hcbd_pkg::ST_DONE, 32'd2, 32'd13}},
    // Byte after the end: not counted, status repeated on last_byte.
    '{ROW_BEAT, 1'b0, 8'h51, 1'b0, 1'b1, 1'b1,
      '{8'h00, 1'b0, hcbd_pkg::ST_DONE, 32'd2, 32'd13}},
    // Extension marker before any digit.
    '{ROW_BEAT, 1'b0, hcbd_pkg::CH_SEMI, 1'b1, 1'b0, 1'b1,
      '{8'h00, 1'b0, hcbd_pkg::ST_ERROR, 32'd0, 32'd1}},
    // Size line closed by a bare LF.
    '{ROW_BEAT, 1'b0, 8'h31, 1'b1, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, hcbd_pkg::CH_LF, 1'b0, 1'b0, 1'b1,
      '{8'h00, 1'b0, hcbd_pkg::ST_ERROR, 32'd0, 32'd2}},
    // Eight digits reach the largest size; a ninth overflows.
    '{ROW_BEAT, 1'b0, 8'h46, 1'b1, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 8'h66, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 8'h46, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 8'h66, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 8'h46, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 8'h66, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 8'h46, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 8'h66, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 8'h37, 1'b0, 1'b0, 1'b1,
      '{8'h00, 1'b0, hcbd_pkg::ST_ERROR, 32'd0, 32'd9}},
    // Content-length also present: the first byte is refused.
    '{ROW_CFG, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 8'h31, 1'b1, 1'b1, 1'b1,
      '{8'h00, 1'b0, hcbd_pkg::ST_ERROR, 32'd0, 32'd1}},
    '{ROW_CFG, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, NONE}
  };

  logic clk = 1'b0;
  logic rst;

  hcbd_in_if  body_bus ();
  hcbd_out_if result_bus ();
  hcbd_cfg_if cfg_bus ();

  http_chunked_body_decoder_top #(
    .SIZE_BITS (SIZE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .body_in   (body_bus),
    .result_out(result_bus),
    .cfg       (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the decoder state and its one register.
  logic                  refuse_body;
  hcbd_pkg::phase_t      body_phase;
  logic [SIZE_BITS-1:0]  chunk_left;
  logic                  size_digit_seen;
  logic [COUNT_BITS-1:0] payload_total;
  logic [COUNT_BITS-1:0] bytes_taken;

  hcbd_pkg::result_t pending_decodes[$];   // results owed by the decoder, oldest first

  // Typed-in expectation for the beat now on the bus, set with the beat.
  logic              pin_valid;
  hcbd_pkg::result_t pin_result;

  bit quiet_tail = 1'b0;   // final stretch: no gaps, no stalls
  int gap_odds;            // per-body chance (out of 8) of a sender gap before a beat

  int mismatches = 0;
  int beats_taken = 0;
  int results_seen = 0;
  int payload_seen = 0;
  int bodies_done = 0;
  int bodies_failed = 0;
  int truncations = 0;
  int cfg_writes = 0;

  // Steps the predictor by one body byte; returns 1 if the decoder owes a result.
  function automatic logic decode_body_byte(input hcbd_pkg::item_t beat,
                                            output hcbd_pkg::result_t res);
    logic [7:0] b;
    logic [7:0] folded;
    logic [3:0] nib;
    logic       is_hex;
    logic       emit;
    logic       ended;
    hcbd_pkg::status_t st;
    b      = beat.data_byte;
    folded = b | 8'h20;   // folds A-F onto a-f
    emit   = 1'b0;
    ended  = 1'b0;
    nib    = 4'h0;
    is_hex = 1'b1;
    if (b >= 8'h30 && b <= 8'h39) nib = b[3:0];
    else if (folded >= 8'h61 && folded <= 8'h66) nib = 4'(folded - 8'h57);
    else is_hex = 1'b0;

    if (beat.start_of_body) begin
      body_phase      = hcbd_pkg::PH_SKIP;
      chunk_left      = '0;
      size_digit_seen = 1'b0;
      payload_total   = '0;
      bytes_taken     = '0;
    end

    if (body_phase != hcbd_pkg::PH_DONE && body_phase != hcbd_pkg::PH_ERROR) begin
      bytes_taken = bytes_taken + 1'b1;
      if (refuse_body) begin
        body_phase = hcbd_pkg::PH_ERROR;
      end else begin
        case (body_phase)
          hcbd_pkg::PH_SKIP, hcbd_pkg::PH_SIZE: begin
            if (body_phase == hcbd_pkg::PH_SKIP &&
                (b == hcbd_pkg::CH_CR || b == hcbd_pkg::CH_LF)) begin
              // stray line break ahead of a size line
            end else if (is_hex) begin
              if (chunk_left > SIZE_SHIFT_MAX) begin
                body_phase = hcbd_pkg::PH_ERROR;
              end else begin
                chunk_left      = {chunk_left[SIZE_BITS-5:0], nib};
                size_digit_seen = 1'b1;
                body_phase      = hcbd_pkg::PH_SIZE;
              end
            end else if ((b == hcbd_pkg::CH_SEMI || b == hcbd_pkg::CH_SPACE) &&
                         size_digit_seen) begin
              body_phase = hcbd_pkg::PH_EXT;
            end else if (b == hcbd_pkg::CH_CR && size_digit_seen) begin
              body_phase = hcbd_pkg::PH_SIZE_LF;
            end else begin
              body_phase = hcbd_pkg::PH_ERROR;
            end
          end
          hcbd_pkg::PH_EXT: begin
            if (b == hcbd_pkg::CH_CR) body_phase = hcbd_pkg::PH_SIZE_LF;
            else if (b == hcbd_pkg::CH_LF) body_phase = hcbd_pkg::PH_ERROR;
          end
          hcbd_pkg::PH_SIZE_LF: begin
            if (b != hcbd_pkg::CH_LF) body_phase = hcbd_pkg::PH_ERROR;
            else if (chunk_left == '0) body_phase = hcbd_pkg::PH_TR_START;
            else body_phase = hcbd_pkg::PH_PAYLOAD;
          end
          hcbd_pkg::PH_PAYLOAD: begin
            emit          = 1'b1;
            payload_total = payload_total + 1'b1;
            chunk_left    = chunk_left - 1'b1;
            if (chunk_left == '0) body_phase = hcbd_pkg::PH_DATA_CR;
          end
          hcbd_pkg::PH_DATA_CR: begin
            body_phase = (b == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_DATA_LF
                                                : hcbd_pkg::PH_ERROR;
          end
          hcbd_pkg::PH_DATA_LF: begin
            if (b == hcbd_pkg::CH_LF) begin
              body_phase      = hcbd_pkg::PH_SKIP;
              size_digit_seen = 1'b0;
            end else begin
              body_phase = hcbd_pkg::PH_ERROR;
            end
          end
          hcbd_pkg::PH_TR_START, hcbd_pkg::PH_TR_LINE: begin
            if (b == hcbd_pkg::CH_CR) body_phase = hcbd_pkg::PH_TR_LF;
            else if (b == hcbd_pkg::CH_LF) body_phase = hcbd_pkg::PH_DONE;
            else body_phase = hcbd_pkg::PH_TR_LINE;
          end
          hcbd_pkg::PH_TR_LF: begin
            body_phase = (b == hcbd_pkg::CH_LF) ? hcbd_pkg::PH_DONE
                                                : hcbd_pkg::PH_ERROR;
          end
          default: body_phase = hcbd_pkg::PH_ERROR;
        endcase
      end
      ended = (body_phase == hcbd_pkg::PH_DONE || body_phase == hcbd_pkg::PH_ERROR);
    end

    if (body_phase == hcbd_pkg::PH_DONE) st = hcbd_pkg::ST_DONE;
    else if (body_phase == hcbd_pkg::PH_ERROR) st = hcbd_pkg::ST_ERROR;
    else if (beat.last_byte) st = hcbd_pkg::ST_INCOMPLETE;
    else st = hcbd_pkg::ST_RUNNING;

    res.payload_byte   = emit ? b : 8'h00;
    res.payload_valid  = emit;
    res.status         = st;
    res.decoded_count  = payload_total[31:0];
    res.consumed_count = bytes_taken[31:0];
    return emit || ended || beat.last_byte;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Scoreboard: results are checked before the beat of this edge is predicted,
  // since a beat's result cannot appear at the edge that accepts it.
  always @(posedge clk) begin : scoreboard
    hcbd_pkg::result_t got;
    hcbd_pkg::result_t want;
    hcbd_pkg::result_t predicted;
    logic    owes;
    if (rst) begin
      refuse_body     = 1'b0;
      body_phase      = hcbd_pkg::PH_SKIP;
      chunk_left      = '0;
      size_digit_seen = 1'b0;
      payload_total   = '0;
      bytes_taken     = '0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        got = {result_bus.payload_byte, result_bus.payload_valid, result_bus.status,
               result_bus.decoded_count, result_bus.consumed_count};
        results_seen++;
        if (got.payload_valid) payload_seen++;
        if (got.status == hcbd_pkg::ST_DONE) bodies_done++;
        if (got.status == hcbd_pkg::ST_ERROR) bodies_failed++;
        if (got.status == hcbd_pkg::ST_INCOMPLETE) truncations++;
        if (pending_decodes.size() == 0) begin
          $error("result beat with nothing expected: status %0d byte %0h",
                 got.status, got.payload_byte);
          mismatches++;
        end else begin
          want = pending_decodes.pop_front();
          check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
          check_field("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("decoded_count", want.decoded_count, got.decoded_count);
          check_field("consumed_count", want.consumed_count, got.consumed_count);
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        refuse_body = cfg_bus.content_length_present;
        cfg_writes++;
      end
      if (body_bus.valid && body_bus.ready) begin
        beats_taken++;
        owes = decode_body_byte({body_bus.data_byte, body_bus.start_of_body,
                                 body_bus.last_byte}, predicted);
        if (pin_valid) pending_decodes.push_back(pin_result);
        else if (owes) pending_decodes.push_back(predicted);
      end
    end
  end

  // Hang detector: any accepted beat on any channel restarts the count.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (body_bus.valid && body_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
          (result_bus.valid && result_bus.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("timeout: no beat for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending_decodes.size());
    $display("** http_chunked_body_decoder_top: FAILED **");
    $finish;
  end

  // Receiver: stalls in random bursts, with calm stretches between.
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      result_bus.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 60)) @(negedge clk);
      else repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  // Drives one body beat from a falling edge and returns at the falling edge
  // after it is taken.
  task automatic send_beat(input hcbd_pkg::item_t beat, input logic pinned,
                           input hcbd_pkg::result_t want);
    if (!quiet_tail && gap_odds != 0 && $urandom_range(1, 8) <= gap_odds) begin
      body_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    body_bus.valid         <= 1'b1;
    body_bus.data_byte     <= beat.data_byte;
    body_bus.start_of_body <= beat.start_of_body;
    body_bus.last_byte     <= beat.last_byte;
    pin_valid              <= pinned;
    pin_result             <= want;
    @(posedge clk);
    while (!body_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits for every owed result, then for a beat with no result to clear.
  task automatic settle();
    body_bus.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_refuse(input logic value);
    cfg_bus.valid                  <= 1'b1;
    cfg_bus.content_length_present <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Hex digits of value, most significant first, mixed case, after pad zeros.
  function automatic void push_hex(ref logic [7:0] q[$], input logic [31:0] value,
                                   input int pad);
    logic [3:0] nib;
    int top;
    repeat (pad) q.push_back(8'h30);
    top = 7;
    while (top > 0 && value[top*4 +: 4] == 4'h0) top--;
    for (int i = top; i >= 0; i--) begin
      nib = value[i*4 +: 4];
      if (nib < 4'd10) q.push_back(8'h30 + 8'(nib));
      else q.push_back(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10);
    end
  endfunction

  // Arbitrary bytes with no line break among them.
  function automatic void push_text(ref logic [7:0] q[$], input int n);
    logic [7:0] ch;
    repeat (n) begin
      ch = 8'($urandom_range(0, 255));
      if (ch == hcbd_pkg::CH_CR || ch == hcbd_pkg::CH_LF) ch = 8'h2D;
      q.push_back(ch);
    end
  endfunction

  function automatic void push_crlf(ref logic [7:0] q[$]);
    q.push_back(hcbd_pkg::CH_CR);
    q.push_back(hcbd_pkg::CH_LF);
  endfunction

  // One chunked body: mostly well formed with random content, sometimes
  // oversized, corrupted, cut short or plain noise.
  function automatic void make_body(ref logic [7:0] q[$]);
    int chunks;
    int size;
    int keep;
    logic [7:0] ch;
    q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2))
      q.push_back($urandom_range(0, 1) ? hcbd_pkg::CH_CR : hcbd_pkg::CH_LF);
    chunks = $urandom_range(0, 3);
    for (int c = 0; c < chunks; c++) begin
      if ($urandom_range(0, 19) == 0) begin
        // nine digits: the last one no longer fits
        push_hex(q, 32'h1000_0000 | 32'($urandom), 0);
        push_hex(q, 32'($urandom_range(0, 15)), 0);
        push_crlf(q);
        return;
      end
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      push_hex(q, 32'(size), $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
      if ($urandom_range(0, 3) == 0) begin
        q.push_back($urandom_range(0, 1) ? hcbd_pkg::CH_SEMI : hcbd_pkg::CH_SPACE);
        push_text(q, $urandom_range(0, 4));
      end
      push_crlf(q);
      repeat (size) q.push_back(8'($urandom_range(0, 255)));
      push_crlf(q);
      if ($urandom_range(0, 5) == 0)
        q.push_back($urandom_range(0, 1) ? hcbd_pkg::CH_CR : hcbd_pkg::CH_LF);
    end
    push_hex(q, 32'd0, $urandom_range(0, 2));
    if ($urandom_range(0, 4) == 0) begin
      q.push_back(hcbd_pkg::CH_SEMI);
      push_text(q, $urandom_range(0, 3));
    end
    push_crlf(q);
    case ($urandom_range(0, 4))
      0: push_crlf(q);
      1: q.push_back(hcbd_pkg::CH_LF);
      2: begin
        push_text(q, $urandom_range(1, 6));
        push_crlf(q);
      end
      3: begin
        push_text(q, $urandom_range(1, 6));
        q.push_back(hcbd_pkg::CH_LF);
      end
      default: begin
        // CR in the trailer not followed by LF
        push_text(q, $urandom_range(0, 3));
        q.push_back(hcbd_pkg::CH_CR);
        ch = 8'($urandom_range(0, 255));
        q.push_back(ch == hcbd_pkg::CH_LF ? 8'h7A : ch);
      end
    endcase
    if ($urandom_range(0, 6) == 0) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, q.size());
      while (q.size() > keep) void'(q.pop_back());
    end
    repeat ($urandom_range(0, 1)) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Random bodies until about beat_goal beats have been sent.
  task automatic run_bodies(input int beat_goal);
    logic [7:0] body[$];
    hcbd_pkg::item_t beat;
    int sent;
    sent = 0;
    while (sent < beat_goal) begin
      make_body(body);
      gap_odds = $urandom_range(0, 3);
      foreach (body[i]) begin
        beat.data_byte = body[i];
        // now and then a body carries on from the previous, cut-short one
        beat.start_of_body = (i == 0) && ($urandom_range(0, 9) != 0);
        if (i == body.size() - 1) beat.last_byte = 1'($urandom_range(0, 1));
        else beat.last_byte = ($urandom_range(0, 11) == 0);
        send_beat(beat, 1'b0, NONE);
        sent++;
      end
    end
  endtask

  initial begin
    hcbd_pkg::item_t beat;
    rst                            = 1'b1;
    body_bus.valid                 = 1'b0;
    body_bus.data_byte             = 8'h00;
    body_bus.start_of_body         = 1'b0;
    body_bus.last_byte             = 1'b0;
    cfg_bus.valid                  = 1'b0;
    cfg_bus.content_length_present = 1'b0;
    pin_valid                      = 1'b0;
    pin_result                     = NONE;
    gap_odds                       = 2;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed plan; register writes wait for the decoder to go idle.
    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_CFG) begin
        settle();
        write_refuse(PLAN[r].cfg_value);
      end else begin
        beat = {PLAN[r].data, PLAN[r].sob, PLAN[r].last};
        send_beat(beat, PLAN[r].pinned, PLAN[r].want);
      end
    end

    // Random bodies with gaps and stalls, a refused stretch, then a calm tail.
    run_bodies(480);
    settle();
    write_refuse(1'b1);
    run_bodies(60);
    settle();
    write_refuse(1'b0);
    quiet_tail = 1'b1;
    run_bodies(260);
    settle();

    $display("Run covered %0d body beats and %0d config writes, giving %0d results",
             beats_taken, cfg_writes, results_seen);
    $display("with %0d payload bytes, %0d bodies done, %0d refused or malformed, %0d cut short.",
             payload_seen, bodies_done, bodies_failed, truncations);
    if (mismatches == 0) begin
      $display("** http_chunked_body_decoder_top: PASSED **");
    end else begin
      $display("** http_chunked_body_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
